@@ rtl/circular_positional_list_defines.svh @@
// Assertion macros shared by the list RTL.
`ifndef CIRCULAR_POSITIONAL_LIST_DEFINES_SVH
`define CIRCULAR_POSITIONAL_LIST_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define CPL_CHECK(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a trigger is followed by a condition in the cycle after it.
`define CPL_CHECK_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);

`endif

@@ rtl/cpl_pkg.sv @@
package cpl_pkg;

   localparam int MODE_W   = 3;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;

   // Request modes; codes 6 and 7 carry no meaning.
   typedef enum logic [MODE_W-1:0] {
      MODE_INS_HEAD = 3'd0,
      MODE_INS_TAIL = 3'd1,
      MODE_INS_POS  = 3'd2,
      MODE_DEL_HEAD = 3'd3,
      MODE_DEL_TAIL = 3'd4,
      MODE_DEL_POS  = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_BADPOS = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   // Internal operation after the request has been decoded.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_INS_HEAD,
      OP_INS_TAIL,
      OP_INS_MID,
      OP_DEL_HEAD,
      OP_DEL_TAIL,
      OP_DEL_MID
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_WALK,
      ST_PLACE,
      ST_LINK,
      ST_VICTIM,
      ST_UNLINK,
      ST_FREE,
      ST_DONE
   } state_type;

endpackage

@@ rtl/circular_positional_list.sv @@
// Bounded ordered list of signed values held as a linked chain of slots.
// Input channel req_* (valid/ready) carries mode, 1-based position and value:
// insert at head, tail or position, or delete from head, tail or position.
// Result channel rsp_* (valid/ready) returns one item per request: the value
// taken out (zero unless a delete succeeded), a status and the new count.
// Items are handled one at a time. Inserts and deletes at a position walk
// the chain to it, a delete at the tail walks the whole list, and inserts
// at head or tail, deletes at the head and errors need no walk. The walk
// follows one link per cycle through the single read port of the link
// memory. The result shows in the same cycle that the block turns ready
// again.
// A finished result waits in the output register; the next item is taken
// while it waits, and only its own result stalls until rsp_ready frees it.
// Reset empties the list at once: slots are handed out from a fresh counter
// and then from a free chain linked through the link memory, so the value
// and link memories need no clearing pass.
`include "circular_positional_list_defines.svh"

module circular_positional_list #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cpl_pkg::MODE_W-1:0]         req_mode,
   input  logic [cpl_pkg::POS_W-1:0]          req_position,
   input  logic signed [VALUE_BITS-1:0]       req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [VALUE_BITS-1:0]       rsp_removed_value,
   output logic [cpl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_entry_count
);

   localparam int AW     = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = ((CNT_W > cpl_pkg::POS_W) ? CNT_W : cpl_pkg::POS_W) + 1;

   // Slot storage: values and links in two synchronous memories.
   logic signed [VALUE_BITS-1:0] value_mem [DEPTH];
   logic [AW-1:0]                link_mem  [DEPTH];

   logic                         val_we, val_re;
   logic [AW-1:0]                val_waddr, val_raddr;
   logic signed [VALUE_BITS-1:0] val_wdata;
   logic signed [VALUE_BITS-1:0] val_rdata_ff;

   logic                         link_we, link_re;
   logic [AW-1:0]                link_waddr, link_raddr, link_wdata;
   logic [AW-1:0]                link_rdata_ff;

   // Control state.
   cpl_pkg::state_type  state_ff, state_in;
   cpl_pkg::op_type     op_ff, op_in;
   cpl_pkg::status_type status_ff, status_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    fresh_ff, fresh_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [AW-1:0]       free_head_ff, free_head_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Per-item working registers.
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [AW-1:0]       prev_ff, prev_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]    hop_ff, hop_in;
   logic                walk_fwd_ff, walk_fwd_in;

   // Output register.
   logic signed [VALUE_BITS-1:0] rsp_removed_value_ff;
   logic [cpl_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]             rsp_entry_count_ff;
   logic                         rsp_load;

   // Decode of the incoming request.
   cpl_pkg::op_type     dec_op;
   cpl_pkg::status_type dec_status;
   logic [CMP_W-1:0]    dec_target;
   logic [CMP_W-1:0]    pos_ext, cnt_ext;
   logic                list_full, list_empty, free_avail;
   logic [AW-1:0]       walk_cur;

   assign pos_ext    = CMP_W'(req_position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign list_full  = (count_ff == CNT_W'(DEPTH));
   assign list_empty = (count_ff == '0);
   // Released slots wait on the free chain; fresh counts slots ever used.
   assign free_avail = (fresh_ff != count_ff);
   // During a walk, follow the link just read instead of the stored pointer.
   assign walk_cur   = walk_fwd_ff ? link_rdata_ff : cur_ff;

   always_comb begin
      dec_op     = cpl_pkg::OP_NONE;
      dec_status = cpl_pkg::STATUS_OK;
      dec_target = pos_ext;
      unique case (req_mode)
         cpl_pkg::MODE_INS_HEAD: begin
            if (list_full) dec_status = cpl_pkg::STATUS_FULL;
            else           dec_op     = cpl_pkg::OP_INS_HEAD;
         end
         cpl_pkg::MODE_INS_TAIL: begin
            if (list_full) dec_status = cpl_pkg::STATUS_FULL;
            else           dec_op     = cpl_pkg::OP_INS_TAIL;
         end
         cpl_pkg::MODE_INS_POS: begin
            priority if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
               dec_status = cpl_pkg::STATUS_BADPOS;
            else if (list_full)
               dec_status = cpl_pkg::STATUS_FULL;
            else if (pos_ext == CMP_W'(1))
               dec_op = cpl_pkg::OP_INS_HEAD;
            else if (pos_ext == cnt_ext + CMP_W'(1))
               dec_op = cpl_pkg::OP_INS_TAIL;
            else
               dec_op = cpl_pkg::OP_INS_MID;
         end
         cpl_pkg::MODE_DEL_HEAD: begin
            if (list_empty) dec_status = cpl_pkg::STATUS_EMPTY;
            else            dec_op     = cpl_pkg::OP_DEL_HEAD;
         end
         cpl_pkg::MODE_DEL_TAIL: begin
            dec_target = cnt_ext;
            priority if (list_empty)         dec_status = cpl_pkg::STATUS_EMPTY;
            else if (cnt_ext == CMP_W'(1))   dec_op     = cpl_pkg::OP_DEL_HEAD;
            else                             dec_op     = cpl_pkg::OP_DEL_TAIL;
         end
         cpl_pkg::MODE_DEL_POS: begin
            priority if (list_empty)
               dec_status = cpl_pkg::STATUS_EMPTY;
            else if (pos_ext == '0 || pos_ext > cnt_ext)
               dec_status = cpl_pkg::STATUS_BADPOS;
            else if (pos_ext == CMP_W'(1))
               dec_op = cpl_pkg::OP_DEL_HEAD;
            else if (pos_ext == cnt_ext)
               dec_op = cpl_pkg::OP_DEL_TAIL;
            else
               dec_op = cpl_pkg::OP_DEL_MID;
         end
         default: dec_status = cpl_pkg::STATUS_BADPOS;
      endcase
   end

   // Sequencer: next state, working registers and memory controls.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_head_in = free_head_ff;
      value_in     = value_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      slot_in      = slot_ff;
      hop_in       = hop_ff;
      walk_fwd_in  = walk_fwd_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_load     = 1'b0;
      req_ready    = 1'b0;
      val_we       = 1'b0;
      val_waddr    = slot_ff;
      val_wdata    = value_ff;
      val_re       = 1'b0;
      val_raddr    = cur_ff;
      link_we      = 1'b0;
      link_waddr   = slot_ff;
      link_wdata   = head_ff;
      link_re      = 1'b0;
      link_raddr   = cur_ff;

      unique case (state_ff)
         cpl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = dec_op;
               status_in   = dec_status;
               value_in    = req_value;
               cur_in      = head_ff;
               walk_fwd_in = 1'b0;
               hop_in      = CNT_W'(dec_target - CMP_W'(1));
               unique case (dec_op)
                  cpl_pkg::OP_INS_HEAD, cpl_pkg::OP_INS_TAIL, cpl_pkg::OP_INS_MID: begin
                     // Fetch the successor on the free chain in case it is used.
                     link_re    = free_avail;
                     link_raddr = free_head_ff;
                     state_in   = cpl_pkg::ST_ALLOC;
                  end
                  cpl_pkg::OP_DEL_HEAD:                     state_in = cpl_pkg::ST_VICTIM;
                  cpl_pkg::OP_DEL_TAIL, cpl_pkg::OP_DEL_MID: state_in = cpl_pkg::ST_WALK;
                  default:                                  state_in = cpl_pkg::ST_DONE;
               endcase
            end
         end
         cpl_pkg::ST_ALLOC: begin
            if (free_avail) begin
               slot_in      = free_head_ff;
               free_head_in = link_rdata_ff;
            end else begin
               slot_in  = fresh_ff[AW-1:0];
               fresh_in = fresh_ff + CNT_W'(1);
            end
            state_in = (op_ff == cpl_pkg::OP_INS_MID) ? cpl_pkg::ST_WALK : cpl_pkg::ST_PLACE;
         end
         cpl_pkg::ST_WALK: begin
            if (hop_ff != '0) begin
               // Advance one link; remember the node behind.
               link_re     = 1'b1;
               link_raddr  = walk_cur;
               prev_in     = walk_cur;
               hop_in      = hop_ff - CNT_W'(1);
               walk_fwd_in = 1'b1;
            end else begin
               cur_in   = walk_cur;
               state_in = (op_ff == cpl_pkg::OP_INS_MID) ? cpl_pkg::ST_PLACE
                                                          : cpl_pkg::ST_VICTIM;
            end
         end
         cpl_pkg::ST_PLACE: begin
            val_we = 1'b1;
            unique case (op_ff)
               cpl_pkg::OP_INS_TAIL: begin
                  link_we    = ~list_empty;
                  link_waddr = tail_ff;
                  link_wdata = slot_ff;
                  tail_in    = slot_ff;
                  if (list_empty) head_in = slot_ff;
                  state_in   = cpl_pkg::ST_DONE;
               end
               cpl_pkg::OP_INS_MID: begin
                  link_we    = 1'b1;
                  link_wdata = cur_ff;
                  state_in   = cpl_pkg::ST_LINK;
               end
               default: begin
                  link_we  = 1'b1;
                  head_in  = slot_ff;
                  if (list_empty) tail_in = slot_ff;
                  state_in = cpl_pkg::ST_DONE;
               end
            endcase
         end
         cpl_pkg::ST_LINK: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = slot_ff;
            state_in   = cpl_pkg::ST_DONE;
         end
         cpl_pkg::ST_VICTIM: begin
            val_re   = 1'b1;
            link_re  = 1'b1;
            state_in = cpl_pkg::ST_UNLINK;
         end
         cpl_pkg::ST_UNLINK: begin
            unique case (op_ff)
               cpl_pkg::OP_DEL_HEAD: head_in = link_rdata_ff;
               cpl_pkg::OP_DEL_TAIL: tail_in = prev_ff;
               default: begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff;
                  link_wdata = link_rdata_ff;
               end
            endcase
            state_in = cpl_pkg::ST_FREE;
         end
         cpl_pkg::ST_FREE: begin
            // Push the released slot onto the free chain.
            link_we      = 1'b1;
            link_waddr   = cur_ff;
            link_wdata   = free_head_ff;
            free_head_in = cur_ff;
            state_in     = cpl_pkg::ST_DONE;
         end
         cpl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               unique case (op_ff)
                  cpl_pkg::OP_INS_HEAD, cpl_pkg::OP_INS_TAIL, cpl_pkg::OP_INS_MID:
                     count_in = count_ff + CNT_W'(1);
                  cpl_pkg::OP_DEL_HEAD, cpl_pkg::OP_DEL_TAIL, cpl_pkg::OP_DEL_MID:
                     count_in = count_ff - CNT_W'(1);
                  default: count_in = count_ff;
               endcase
               state_in = cpl_pkg::ST_IDLE;
            end
         end
         default: state_in = cpl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpl_pkg::ST_IDLE;
         count_ff     <= '0;
         fresh_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      slot_ff     <= slot_in;
      hop_ff      <= hop_in;
      walk_fwd_ff <= walk_fwd_in;
      if (rsp_load) begin
         // Drop the read value unless a delete produced it.
         if (op_ff == cpl_pkg::OP_DEL_HEAD || op_ff == cpl_pkg::OP_DEL_TAIL ||
             op_ff == cpl_pkg::OP_DEL_MID)
            rsp_removed_value_ff <= val_rdata_ff;
         else
            rsp_removed_value_ff <= '0;
         rsp_status_ff      <= status_ff;
         rsp_entry_count_ff <= count_in;
      end
   end

   // Value memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (val_we) value_mem[val_waddr] <= val_wdata;
      if (val_re) val_rdata_ff <= value_mem[val_raddr];
   end

   // Link memory: list links and the free chain share it.
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (link_re) link_rdata_ff <= link_mem[link_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;

   `CPL_CHECK(a_free_chain_len, fresh_ff >= count_ff && fresh_ff <= CNT_W'(DEPTH), "slot accounting broken")
   `CPL_CHECK(a_full_status, !(state_ff == cpl_pkg::ST_DONE && status_ff == cpl_pkg::STATUS_FULL) || list_full, "full status on a list with room")
   `CPL_CHECK_NEXT(a_count_hold, !rsp_load, $stable(count_ff), "count moved without a result")
   `CPL_CHECK_NEXT(a_busy_after_accept, req_valid && req_ready, state_ff != cpl_pkg::ST_IDLE, "accept left the sequencer idle")

endmodule
